[rtl/core/dcwf_pkg.sv]
// shared types and constants for the dds channel write framer
// no dependencies; imported by every module of the block
package dcwf_pkg;

   // command kinds
   typedef enum logic [1:0] {
      FUNC_FREQ  = 2'd0,
      FUNC_AMPL  = 2'd1,
      FUNC_PHASE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // range limits and fallback values
   localparam logic [31:0] FREQ_MAX      = 32'd500000000;
   localparam logic [31:0] FREQ_FALLBACK = 32'd114514;
   localparam logic [8:0]  AMPL_MAX      = 9'd511;
   localparam logic [8:0]  AMPL_FALLBACK = 9'd114;
   localparam logic [31:0] PHASE_LIMIT   = 32'd16383;

   // register addresses of the dds serial port
   localparam logic [7:0] ADDR_SELECT = 8'h00;
   localparam logic [7:0] ADDR_FREQ   = 8'h04;
   localparam logic [7:0] ADDR_PHASE  = 8'h05;
   localparam logic [7:0] ADDR_AMPL   = 8'h06;
   localparam logic [7:0] CH_ENABLE   = 8'h10;

   // tuning scale register
   localparam int          SCALE_W     = 40;
   localparam logic [39:0] SCALE_RESET = 40'd36893488147;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // byte slots of one command
   typedef enum logic [2:0] {
      SLOT_SEL   = 3'd0,
      SLOT_EN    = 3'd1,
      SLOT_ADDR  = 3'd2,
      SLOT_DATA0 = 3'd3,
      SLOT_DATA1 = 3'd4,
      SLOT_DATA2 = 3'd5,
      SLOT_DATA3 = 3'd6
   } slot_type;

   // one classified command, data right aligned
   typedef struct packed {
      func_type    func;
      logic        ch_ok;
      logic [1:0]  ch;
      logic        err;
      logic [31:0] data;
   } cmd_type;

   // push side of the queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // number of data bytes of a command kind
   function automatic logic [2:0] data_bytes(input func_type f);
      logic [2:0] n;
      unique case (f)
         FUNC_FREQ:  n = 3'd4;
         FUNC_AMPL:  n = 3'd3;
         FUNC_PHASE: n = 3'd2;
         default:    n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

[rtl/core/dcwf_front.sv]
// front: accepts commands, clamps values, forms the tuning word
// depends on dcwf_pkg; feeds dcwf_queue
module dcwf_front
   import dcwf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_channel,
   input  logic [31:0]        req_value,
   input  logic               csr_wr_en,
   input  logic [SCALE_W-1:0] csr_wr_data,
   input  logic               queue_full,
   output push_type           push
);

   logic [SCALE_W-1:0] scale_ff;
   logic               a_valid_ff, a_valid_in;
   cmd_type            a_cmd_ff;
   cmd_type            a_cmd_in;
   logic               b_valid_ff, b_valid_in;
   cmd_type            b_cmd_ff;
   logic [63:0]        b_prod_lo_ff;
   logic [39:0]        b_prod_hi_ff;
   logic               adv_a, adv_b, accept;
   func_type           func;
   logic [8:0]         ampl;
   logic [31:0]        word;

   // tuning scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // pipeline flow, stall only when the queue is full
   assign adv_b     = !b_valid_ff || !queue_full;
   assign adv_a     = !a_valid_ff || adv_b;
   assign req_stall = !adv_a;
   assign accept    = req_valid && adv_a;
   assign func      = func_type'(req_func);

   // classify and clamp
   always_comb begin
      a_cmd_in       = '0;
      a_cmd_in.func  = func;
      a_cmd_in.ch    = req_channel[1:0];
      a_cmd_in.ch_ok = (req_channel < 4'd4);
      a_cmd_in.err   = (req_channel > 4'd3);
      a_cmd_in.data  = req_value;
      ampl           = req_value[8:0];
      unique case (func)
         FUNC_FREQ: begin
            if (req_value == 32'd0 || req_value > FREQ_MAX) begin
               a_cmd_in.data = FREQ_FALLBACK;
               a_cmd_in.err  = 1'b1;
            end
         end
         FUNC_AMPL: begin
            if (req_value > {23'd0, AMPL_MAX}) begin
               ampl         = AMPL_FALLBACK;
               a_cmd_in.err = 1'b1;
            end
            // value doubled, bit 12 set
            a_cmd_in.data = {19'd0, 1'b1, 2'd0, ampl, 1'b0};
         end
         FUNC_PHASE: begin
            if (req_value > PHASE_LIMIT) begin
               a_cmd_in.data = PHASE_LIMIT;
               a_cmd_in.err  = 1'b1;
            end
         end
         default: begin
            a_cmd_in.data = req_value;
         end
      endcase
   end

   // stage a: classified command; unused kind is dropped here
   assign a_valid_in = adv_a ? (accept && func != FUNC_NONE) : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_cmd_ff <= a_cmd_in;
      end
   end

   // stage b: partial products of frequency times scale
   assign b_valid_in = adv_b ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         b_cmd_ff     <= a_cmd_ff;
         b_prod_lo_ff <= 64'(a_cmd_ff.data) * 64'(scale_ff[31:0]);
         b_prod_hi_ff <= 40'(a_cmd_ff.data) * 40'(scale_ff[39:32]);
      end
   end

   // tuning word, kept mod 2^32
   assign word = b_prod_hi_ff[31:0] + b_prod_lo_ff[63:32];

   always_comb begin
      push.valid = b_valid_ff && !queue_full;
      push.cmd   = b_cmd_ff;
      if (b_cmd_ff.func == FUNC_FREQ) begin
         push.cmd.data = word;
      end
   end

endmodule

[rtl/core/dcwf_queue.sv]
// small queue of classified commands between front and back
// depends on dcwf_pkg
module dcwf_queue
   import dcwf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output cmd_type  head
);

   cmd_type              mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // storage write
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.cmd;
      end
   end

   // pointers and fill count
   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

[rtl/core/dcwf_back.sv]
// back: walks the byte slots of one command and drives the output word
// depends on dcwf_pkg; takes commands from dcwf_queue
module dcwf_back
   import dcwf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_spi_byte,
   output logic        rsp_is_address,
   output logic        rsp_frame_end,
   output logic        rsp_update_pulse,
   output logic        rsp_error,
   output logic        rsp_last
);

   cmd_type    cur_ff;
   logic       busy_ff, busy_in;
   slot_type   slot_ff, slot_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       addr_ff, addr_in;
   logic       fend_ff, fend_in;
   logic       upd_ff, upd_in;
   logic       err_ff;
   logic       last_ff, last_in;
   logic       emit, load;
   logic [2:0] n, idx, sel;

   // one byte leaves when the output register is free
   assign emit = busy_ff && (!out_valid_ff || !rsp_stall);
   assign n    = data_bytes(cur_ff.func);
   assign idx  = 3'(slot_ff) - 3'(SLOT_DATA0);
   assign sel  = n - 3'd1 - idx;

   // byte of the current slot
   always_comb begin
      byte_in = '0;
      addr_in = 1'b0;
      fend_in = 1'b0;
      upd_in  = 1'b0;
      last_in = 1'b0;
      unique case (slot_ff)
         SLOT_SEL: begin
            byte_in = ADDR_SELECT;
            addr_in = 1'b1;
         end
         SLOT_EN: begin
            byte_in = CH_ENABLE << cur_ff.ch;
            fend_in = 1'b1;
         end
         SLOT_ADDR: begin
            addr_in = 1'b1;
            case (cur_ff.func)
               FUNC_FREQ:  byte_in = ADDR_FREQ;
               FUNC_AMPL:  byte_in = ADDR_AMPL;
               default:    byte_in = ADDR_PHASE;
            endcase
         end
         default: begin
            case (sel[1:0])
               2'd0:    byte_in = cur_ff.data[7:0];
               2'd1:    byte_in = cur_ff.data[15:8];
               2'd2:    byte_in = cur_ff.data[23:16];
               default: byte_in = cur_ff.data[31:24];
            endcase
            fend_in = (sel == 3'd0);
            upd_in  = (sel == 3'd0);
            last_in = (sel == 3'd0);
         end
      endcase
   end

   // take the next command as the current one finishes
   assign load = head_valid && (!busy_ff || (emit && last_in));
   assign pop  = load;

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (emit) begin
         slot_in = slot_type'(3'(slot_ff) + 3'd1);
         if (last_in) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         slot_in = head.ch_ok ? SLOT_SEL : SLOT_ADDR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= SLOT_SEL;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= head;
      end
   end

   // output word register
   assign out_valid_in = emit ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         addr_ff <= addr_in;
         fend_ff <= fend_in;
         upd_ff  <= upd_in;
         err_ff  <= cur_ff.err;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_spi_byte     = byte_ff;
   assign rsp_is_address   = addr_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_update_pulse = upd_ff;
   assign rsp_error        = err_ff;
   assign rsp_last         = last_ff;

endmodule

[rtl/core/dds_channel_write_framer_top.sv]
// first byte path: front stages a and b, queue, back command and output registers
// throughput: one byte word per cycle unless rsp_stall; a command is 3 to 7 bytes
//   from the byte sequencer (one or two frames, up to seven bytes); commands queue
// reset: synchronous, clears all valid state and restores the default scale
// depends on dcwf_pkg, dcwf_front, dcwf_queue, dcwf_back
module dds_channel_write_framer_top
   import dcwf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_channel,
   input  logic [31:0]        req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_spi_byte,
   output logic               rsp_is_address,
   output logic               rsp_frame_end,
   output logic               rsp_update_pulse,
   output logic               rsp_error,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [SCALE_W-1:0] csr_wr_data
);

   push_type push;
   logic     queue_full;
   logic     pop;
   logic     head_valid;
   cmd_type  head;

   // front: classify and compute
   dcwf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_channel (req_channel),
      .req_value   (req_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push)
   );

   // command queue
   dcwf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: byte sequencer
   dcwf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_spi_byte     (rsp_spi_byte),
      .rsp_is_address   (rsp_is_address),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_update_pulse (rsp_update_pulse),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

endmodule
